// File: hdl/kcis_pkg.sv
package kcis_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int CFG_W        = 6;
    localparam int KEY_W        = 64;
    localparam int PAY_W        = 32;

    localparam logic [CFG_W-1:0] MAX_CHECKS_RST = 6'd5;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_SWEEP  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LK_RD,
        ST_LK_CMP,
        ST_SW_STEP,
        ST_SW_WR,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic do_add;
        logic do_clr;
        logic lk_start;
        logic lk_cmp;
        logic sw_start;
        logic sw_step;
        logic sw_write;
        logic sw_finish;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    lk_end;
        logic    lk_match;
        logic    sw_end;
        logic    sw_copy;
        logic    out_free;
    } dp_stat_t;

endpackage

// File: hdl/kcis_ctrl.sv
module kcis_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kcis_pkg::dp_stat_t stat,
    output kcis_pkg::dp_cmd_t  cmd
);

    kcis_pkg::state_t state_reg;
    kcis_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kcis_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kcis_pkg::ST_IDLE: begin
                if (s_valid) state_next = kcis_pkg::ST_DECODE;
            end
            kcis_pkg::ST_DECODE: begin
                case (stat.action)
                    kcis_pkg::ACT_LOOKUP: state_next = kcis_pkg::ST_LK_RD;
                    kcis_pkg::ACT_SWEEP:  state_next = kcis_pkg::ST_SW_STEP;
                    default:              state_next = kcis_pkg::ST_PUSH;
                endcase
            end
            kcis_pkg::ST_LK_RD: begin
                state_next = stat.lk_end ? kcis_pkg::ST_PUSH : kcis_pkg::ST_LK_CMP;
            end
            kcis_pkg::ST_LK_CMP: begin
                state_next = stat.lk_match ? kcis_pkg::ST_PUSH : kcis_pkg::ST_LK_RD;
            end
            kcis_pkg::ST_SW_STEP: begin
                if (stat.sw_end) begin
                    state_next = kcis_pkg::ST_PUSH;
                end else if (stat.sw_copy) begin
                    state_next = kcis_pkg::ST_SW_WR;
                end
            end
            kcis_pkg::ST_SW_WR: begin
                state_next = kcis_pkg::ST_SW_STEP;
            end
            kcis_pkg::ST_PUSH: begin
                if (stat.out_free) state_next = kcis_pkg::ST_IDLE;
            end
            default: state_next = kcis_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            kcis_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            kcis_pkg::ST_DECODE: begin
                case (stat.action)
                    kcis_pkg::ACT_LOOKUP: cmd.lk_start = 1'b1;
                    kcis_pkg::ACT_ADD:    cmd.do_add   = 1'b1;
                    kcis_pkg::ACT_SWEEP:  cmd.sw_start = 1'b1;
                    kcis_pkg::ACT_CLEAR:  cmd.do_clr   = 1'b1;
                    default:              cmd.do_clr   = 1'b0;
                endcase
            end
            kcis_pkg::ST_LK_CMP: begin
                cmd.lk_cmp = 1'b1;
            end
            kcis_pkg::ST_SW_STEP: begin
                cmd.sw_finish = stat.sw_end;
                cmd.sw_step   = !stat.sw_end;
            end
            kcis_pkg::ST_SW_WR: begin
                cmd.sw_write = 1'b1;
            end
            kcis_pkg::ST_PUSH: begin
                cmd.push = stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: hdl/kcis_dp.sv
module kcis_dp #(
    parameter int CAPACITY = kcis_pkg::CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [kcis_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic [1:0]                 s_action,
    input  logic [kcis_pkg::KEY_W-1:0] s_key,
    input  logic [kcis_pkg::PAY_W-1:0] s_payload,
    input  logic                       s_full_collect,
    input  logic                       s_force_clear,
    input  kcis_pkg::dp_cmd_t          cmd,
    output kcis_pkg::dp_stat_t         stat,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [kcis_pkg::PAY_W-1:0] m_payload_out,
    output logic                       m_more_pending,
    output logic                       m_add_dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [kcis_pkg::CFG_W-1:0] CHK_ONE = {{(kcis_pkg::CFG_W-1){1'b0}}, 1'b1};

    // table storage
    logic [kcis_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [kcis_pkg::PAY_W-1:0] pay_mem [CAPACITY];
    logic [kcis_pkg::KEY_W-1:0] key_q_reg;
    logic [kcis_pkg::PAY_W-1:0] pay_q_reg;
    logic [CAPACITY-1:0]        used_reg;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             cursor_reg;
    logic [CW-1:0]             rd_reg;
    logic [CW-1:0]             wr_reg;
    logic                      changed_reg;
    logic [kcis_pkg::CFG_W-1:0] maxc_reg;
    logic [kcis_pkg::CFG_W-1:0] checked_reg;

    // captured beat
    kcis_pkg::action_t          act_reg;
    logic [kcis_pkg::KEY_W-1:0] key_reg;
    logic [kcis_pkg::PAY_W-1:0] pay_reg;
    logic                       full_reg;
    logic                       force_reg;

    logic                       hit_reg;
    logic [kcis_pkg::PAY_W-1:0] pout_reg;
    logic                       more_reg;
    logic                       drop_reg;

    logic                       mv_reg;
    logic                       mh_reg;
    logic [kcis_pkg::PAY_W-1:0] mp_reg;
    logic                       mm_reg;
    logic                       md_reg;

    logic                       examining;
    logic                       erase;
    logic                       rd_eq_wr;
    logic                       rd_end;
    logic                       tbl_full;
    logic                       sw_copy;
    logic [CW-1:0]              new_cnt;
    logic [CW-1:0]              sw_base;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [kcis_pkg::KEY_W-1:0] mem_wk;
    logic [kcis_pkg::PAY_W-1:0] mem_wp;

    assign examining = full_reg || (checked_reg < maxc_reg);
    assign erase     = force_reg || !used_reg[rd_reg[AW-1:0]];
    assign rd_eq_wr  = (rd_reg == wr_reg);
    assign rd_end    = (rd_reg >= count_reg);
    assign tbl_full  = (count_reg >= CAP_C);
    assign sw_copy   = !rd_eq_wr && (!examining || !erase);
    assign new_cnt   = count_reg - rd_reg + wr_reg;
    assign sw_base   = changed_reg ? '0 : cursor_reg;

    assign stat.action   = act_reg;
    assign stat.lk_end   = rd_end;
    assign stat.lk_match = (key_q_reg == key_reg);
    assign stat.sw_end   = rd_end || (!examining && rd_eq_wr);
    assign stat.sw_copy  = sw_copy;
    assign stat.out_free = !mv_reg || m_ready;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = wr_reg[AW-1:0];
        mem_wk = key_q_reg;
        mem_wp = pay_q_reg;
        if (cmd.do_add) begin
            mem_we = !tbl_full;
            mem_wa = count_reg[AW-1:0];
            mem_wk = key_reg;
            mem_wp = pay_reg;
        end else if (cmd.sw_write) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_wa] <= mem_wk;
            pay_mem[mem_wa] <= mem_wp;
        end
        key_q_reg <= key_mem[rd_reg[AW-1:0]];
        pay_q_reg <= pay_mem[rd_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            rd_reg      <= '0;
            wr_reg      <= '0;
            changed_reg <= 1'b0;
            maxc_reg    <= kcis_pkg::MAX_CHECKS_RST;
            checked_reg <= '0;
            used_reg    <= '0;
            mv_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) maxc_reg <= cfg_wr_data;
            if (cmd.do_add && !tbl_full) begin
                used_reg[count_reg[AW-1:0]] <= 1'b1;
                count_reg   <= count_reg + ONE_C;
                changed_reg <= 1'b1;
            end
            if (cmd.do_clr) begin
                used_reg   <= '0;
                cursor_reg <= '0;
            end
            if (cmd.lk_start) rd_reg <= '0;
            if (cmd.lk_cmp) begin
                if (stat.lk_match) begin
                    used_reg[rd_reg[AW-1:0]] <= 1'b1;
                end else begin
                    rd_reg <= rd_reg + ONE_C;
                end
            end
            if (cmd.sw_start) begin
                changed_reg <= 1'b0;
                cursor_reg  <= sw_base;
                rd_reg      <= sw_base;
                wr_reg      <= sw_base;
                checked_reg <= '0;
            end
            if (cmd.sw_step) begin
                if (examining) begin
                    if (!full_reg) checked_reg <= checked_reg + CHK_ONE;
                    if (!erase) cursor_reg <= wr_reg + ONE_C;
                end
                if (!sw_copy) begin
                    rd_reg <= rd_reg + ONE_C;
                    if (!(examining && erase)) wr_reg <= wr_reg + ONE_C;
                end
            end
            if (cmd.sw_write) begin
                used_reg[wr_reg[AW-1:0]] <= used_reg[rd_reg[AW-1:0]];
                rd_reg <= rd_reg + ONE_C;
                wr_reg <= wr_reg + ONE_C;
            end
            if (cmd.sw_finish) count_reg <= new_cnt;
            if (cmd.push) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg   <= kcis_pkg::action_t'(s_action);
            key_reg   <= s_key;
            pay_reg   <= s_payload;
            full_reg  <= s_full_collect;
            force_reg <= s_force_clear;
            hit_reg   <= 1'b0;
            pout_reg  <= '0;
            more_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        if (cmd.do_add) drop_reg <= tbl_full;
        if (cmd.lk_cmp && stat.lk_match) begin
            hit_reg  <= 1'b1;
            pout_reg <= pay_q_reg;
        end
        if (cmd.sw_finish) more_reg <= (cursor_reg < new_cnt);
        if (cmd.push) begin
            mh_reg <= hit_reg;
            mp_reg <= pout_reg;
            mm_reg <= more_reg;
            md_reg <= drop_reg;
        end
    end

    assign m_valid        = mv_reg;
    assign m_hit          = mh_reg;
    assign m_payload_out  = mp_reg;
    assign m_more_pending = mm_reg;
    assign m_add_dropped  = md_reg;

endmodule

// File: hdl/keyed_cache_with_incremental_sweep.sv
// Add and used-bit reset go from decode to push; lookup alternates read and compare states
// per entry up to a hit or the table end; sweep runs a step state per entry stepped and a
// write state per entry moved. One beat in flight; the next is taken once the result is
// in the output register. Storage: one read and one write port, one entry/cycle.
// Reset (aresetn low, synchronous) empties the table, clears used bits, cursor and the
// changed flag, and sets max_checks to 5; no clearing pass is needed.
module keyed_cache_with_incremental_sweep #(
    parameter int CAPACITY = kcis_pkg::CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [kcis_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [kcis_pkg::KEY_W-1:0] s_key,
    input  logic [kcis_pkg::PAY_W-1:0] s_payload,
    input  logic                       s_full_collect,
    input  logic                       s_force_clear,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [kcis_pkg::PAY_W-1:0] m_payload_out,
    output logic                       m_more_pending,
    output logic                       m_add_dropped
);

    kcis_pkg::dp_cmd_t  cmd;
    kcis_pkg::dp_stat_t stat;

    kcis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kcis_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_action       (s_action),
        .s_key          (s_key),
        .s_payload      (s_payload),
        .s_full_collect (s_full_collect),
        .s_force_clear  (s_force_clear),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_payload_out  (m_payload_out),
        .m_more_pending (m_more_pending),
        .m_add_dropped  (m_add_dropped)
    );

endmodule

// File: hdl/kcis_chk.sv
module kcis_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_hit,
    input logic [kcis_pkg::PAY_W-1:0] m_payload_out,
    input logic                       m_more_pending,
    input logic                       m_add_dropped
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_out) && $stable(m_hit))
        else $error("result beat changed while stalled");

    // one beat at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_payload_out == '0)
        else $error("payload_out nonzero without hit");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_hit, m_more_pending, m_add_dropped}) <= 1)
        else $error("result flags from more than one action");

endmodule

bind keyed_cache_with_incremental_sweep kcis_chk u_kcis_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hit          (m_hit),
    .m_payload_out  (m_payload_out),
    .m_more_pending (m_more_pending),
    .m_add_dropped  (m_add_dropped)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH = kcis_pkg::CAPACITY_DEF;
    localparam int PHASE_ITEMS = 118;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        kcis_pkg::action_t          action;
        logic [kcis_pkg::KEY_W-1:0] key;
        logic [kcis_pkg::PAY_W-1:0] payload;
        logic                       full_collect;
        logic                       force_clear;
    } cache_req_t;

    typedef struct {
        logic                       hit;
        logic [kcis_pkg::PAY_W-1:0] payload_out;
        logic                       more_pending;
        logic                       add_dropped;
    } cache_resp_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [kcis_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_action = '0;
    logic [kcis_pkg::KEY_W-1:0] s_key = '0;
    logic [kcis_pkg::PAY_W-1:0] s_payload = '0;
    logic                       s_full_collect = 1'b0;
    logic                       s_force_clear = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_hit;
    logic [kcis_pkg::PAY_W-1:0] m_payload_out;
    logic                       m_more_pending;
    logic                       m_add_dropped;

    keyed_cache_with_incremental_sweep #(
        .CAPACITY(kcis_pkg::CAPACITY_DEF)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .s_full_collect(s_full_collect),
        .s_force_clear (s_force_clear),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_payload_out (m_payload_out),
        .m_more_pending(m_more_pending),
        .m_add_dropped (m_add_dropped)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow copy of the table
    logic [kcis_pkg::KEY_W-1:0] tbl_keys [TABLE_DEPTH];
    logic [kcis_pkg::PAY_W-1:0] tbl_pays [TABLE_DEPTH];
    logic                       tbl_used [TABLE_DEPTH];
    int                         tbl_count = 0;
    int                         tbl_cursor = 0;
    logic                       tbl_changed = 1'b0;
    logic [kcis_pkg::CFG_W-1:0] tbl_max_checks = kcis_pkg::MAX_CHECKS_RST;

    cache_req_t  pending_reqs [$];
    cache_resp_t expected_resps [$];
    logic [kcis_pkg::KEY_W-1:0] key_pool [12];
    int mismatches = 0;

    function automatic cache_resp_t predict_cache_resp(cache_req_t rq);
        cache_resp_t rs;
        int checked;
        rs = '{hit: 1'b0, payload_out: '0, more_pending: 1'b0, add_dropped: 1'b0};
        checked = 0;
        case (rq.action)
            kcis_pkg::ACT_LOOKUP: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_keys[i] == rq.key) begin
                        tbl_used[i] = 1'b1;
                        rs.hit = 1'b1;
                        rs.payload_out = tbl_pays[i];
                        break;
                    end
                end
            end
            kcis_pkg::ACT_ADD: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    rs.add_dropped = 1'b1;
                end else begin
                    tbl_keys[tbl_count] = rq.key;
                    tbl_pays[tbl_count] = rq.payload;
                    tbl_used[tbl_count] = 1'b1;
                    tbl_count++;
                    tbl_changed = 1'b1;
                end
            end
            kcis_pkg::ACT_SWEEP: begin
                if (tbl_changed) begin
                    tbl_cursor = 0;
                    tbl_changed = 1'b0;
                end
                while (tbl_cursor < tbl_count) begin
                    if (!rq.full_collect) begin
                        if (checked >= tbl_max_checks)
                            break;
                        checked++;
                    end
                    if (rq.force_clear || !tbl_used[tbl_cursor]) begin
                        // close the gap, keeping order
                        for (int i = tbl_cursor; i + 1 < tbl_count; i++) begin
                            tbl_keys[i] = tbl_keys[i + 1];
                            tbl_pays[i] = tbl_pays[i + 1];
                            tbl_used[i] = tbl_used[i + 1];
                        end
                        tbl_count--;
                    end else begin
                        tbl_cursor++;
                    end
                end
                rs.more_pending = (tbl_cursor < tbl_count);
            end
            default: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    tbl_used[i] = 1'b0;
                tbl_cursor = 0;
            end
        endcase
        return rs;
    endfunction

    function automatic int draw_gap(int beats);
        // every third stretch of 40 beats runs without idling
        return ((beats / 40) % 3 == 2) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [kcis_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 11)];
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(kcis_pkg::action_t act, logic [kcis_pkg::KEY_W-1:0] key,
                            logic [kcis_pkg::PAY_W-1:0] pay, logic full, logic force_all);
        cache_req_t rq;
        rq = '{action: act, key: key, payload: pay, full_collect: full, force_clear: force_all};
        pending_reqs.push_back(rq);
    endtask

    task automatic load_directed();
        push_req(kcis_pkg::ACT_SWEEP, '0, '0, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_LOOKUP, '0, '1, 1'b1, 1'b1);
        push_req(kcis_pkg::ACT_CLEAR, '1, '0, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_ADD, '0, '0, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_ADD, '1, '1, 1'b1, 1'b1);
        push_req(kcis_pkg::ACT_ADD, '0, 32'h1234_5678, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_ADD, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_LOOKUP, '0, $urandom, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_LOOKUP, '1, $urandom, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_LOOKUP, 64'hA5A5_A5A5_A5A5_A5A5, $urandom, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_CLEAR, 64'($urandom), $urandom, 1'b1, 1'b1);
        push_req(kcis_pkg::ACT_LOOKUP, '1, '0, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_SWEEP, '0, '0, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_ADD, 64'h0123_4567_89AB_CDEF, $urandom, 1'b0, 1'b0);
        push_req(kcis_pkg::ACT_SWEEP, '0, '0, 1'b1, 1'b0);
        push_req(kcis_pkg::ACT_SWEEP, '0, '0, 1'b0, 1'b1);
        push_req(kcis_pkg::ACT_SWEEP, '0, '0, 1'b1, 1'b1);
        push_req(kcis_pkg::ACT_LOOKUP, '1, '0, 1'b0, 1'b0);
    endtask

    task automatic gen_random(int n);
        int base, len;
        base = pending_reqs.size();
        while (pending_reqs.size() - base < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    len = $urandom_range(0, 1) ? $urandom_range(20, 40) : $urandom_range(2, 8);
                    repeat (len)
                        push_req(kcis_pkg::ACT_ADD, pick_key(), $urandom,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                2, 3: begin
                    repeat ($urandom_range(2, 10))
                        push_req(kcis_pkg::ACT_LOOKUP, pick_key(), $urandom,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                4: begin
                    // mark and sweep round
                    push_req(kcis_pkg::ACT_CLEAR, {$urandom, $urandom}, $urandom,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 8))
                        push_req(kcis_pkg::ACT_LOOKUP, pick_key(), $urandom,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 4))
                        push_req(kcis_pkg::ACT_SWEEP, {$urandom, $urandom}, $urandom,
                                 $urandom_range(0, 3) == 0, 1'b0);
                end
                5: begin
                    repeat ($urandom_range(1, 3))
                        push_req(kcis_pkg::ACT_SWEEP, {$urandom, $urandom}, $urandom,
                                 1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0);
                end
                default: begin
                    push_req(kcis_pkg::action_t'($urandom_range(0, 3)), {$urandom, $urandom},
                             $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_resps.size() != 0)
            @(negedge aclk);
    endtask

    // request driver
    cache_req_t cur_req;
    int send_gap = 0;
    int sent_beats = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_resps.push_back(predict_cache_resp(cur_req));
                sent_beats++;
                send_gap = draw_gap(sent_beats);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_action       <= cur_req.action;
                    s_key          <= cur_req.key;
                    s_payload      <= cur_req.payload;
                    s_full_collect <= cur_req.full_collect;
                    s_force_clear  <= cur_req.force_clear;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int recv_gap = 0;
    int recv_beats = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        cache_resp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                recv_beats++;
                if (expected_resps.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_resps.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_hit);
                        mismatches++;
                    end
                    if (m_payload_out !== want.payload_out) begin
                        $error("payload_out: expected %h, got %h",
                               want.payload_out, m_payload_out);
                        mismatches++;
                    end
                    if (m_more_pending !== want.more_pending) begin
                        $error("more_pending: expected %0d, got %0d",
                               want.more_pending, m_more_pending);
                        mismatches++;
                    end
                    if (m_add_dropped !== want.add_dropped) begin
                        $error("add_dropped: expected %0d, got %0d",
                               want.add_dropped, m_add_dropped);
                        mismatches++;
                    end
                end
                recv_gap = draw_gap(recv_beats);
                // long back-pressure so the input side stalls
                if (recv_beats == 400)
                    hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [kcis_pkg::CFG_W-1:0] cfg_val;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tbl_used[i] = 1'b0;
        for (int i = 0; i < 12; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        load_directed();
        gen_random(PHASE_ITEMS);
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            case (p)
                0: cfg_val = 6'd0;
                1: cfg_val = 6'd63;
                2: cfg_val = 6'd1;
                3: cfg_val = 6'd32;
                4: cfg_val = kcis_pkg::CFG_W'($urandom_range(2, 31));
                default: cfg_val = kcis_pkg::MAX_CHECKS_RST;
            endcase
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= cfg_val;
            tbl_max_checks = cfg_val;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            @(negedge aclk);
            if (p == 3)
                key_pool[$urandom_range(0, 11)] = {$urandom, $urandom};
            gen_random(PHASE_ITEMS);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
